>>> sv/atct_pkg.sv
package atct_pkg;

   // Width of every threshold register and of the configuration data.
   localparam int THRESH_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CODE_WIDTH = 3;
   localparam int MASK_WIDTH = 5;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOW_NEG = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HIGH_NEG = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HIGH_POS = 2'd2;

   // Reset levels in 0.1 mV units.
   localparam logic signed [THRESH_WIDTH-1:0] LOW_NEG_RESET = -16'sd150;
   localparam logic signed [THRESH_WIDTH-1:0] HIGH_NEG_RESET = -16'sd1200;
   localparam logic signed [THRESH_WIDTH-1:0] HIGH_POS_RESET = 16'sd1200;

   // Bit positions in the crossed mask.
   localparam int FLAG_R0 = 0;
   localparam int FLAG_R1 = 1;
   localparam int FLAG_R3 = 2;
   localparam int FLAG_R2 = 3;
   localparam int FLAG_R4 = 4;

   typedef enum logic [CODE_WIDTH-1:0] {
      CROSS_NONE = 3'd0,
      CROSS_R0   = 3'd1,
      CROSS_R1   = 3'd2,
      CROSS_R3   = 3'd3,
      CROSS_R2   = 3'd4,
      CROSS_R4   = 3'd5
   } cross_code_type;

   typedef struct packed {
      logic signed [THRESH_WIDTH-1:0] low_neg;
      logic signed [THRESH_WIDTH-1:0] high_neg;
      logic signed [THRESH_WIDTH-1:0] high_pos;
   } thresh_type;

endpackage

>>> sv/anode_threshold_crossing_timer_top.sv
// A request accepted at a clock edge is evaluated from the input register and moves
// into the result register, with rsp_tvalid high, once that is free or drained.
// Throughput: one request per cycle, limited only by rsp_tready; the single
// state update (previous sample and crossed flags) is done as the request moves.
// Reset (synchronous, active high) empties both stages, clears the previous
// sample and the crossed flags, and loads the default thresholds.
module anode_threshold_crossing_timer_top #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int TIME_WIDTH = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // Sample requests.
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // Fields from bit 0 up: sample, sample_time, zero fill.
   input  logic [((SAMPLE_WIDTH+TIME_WIDTH+7)/8)*8-1:0] req_tdata,
   // Fields from bit 0 up: first_sample.
   input  logic                                    req_tuser,
   // Results.
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // Fields from bit 0 up: crossed_register, crossing_time, crossed_mask,
   // zero fill.
   output logic [((TIME_WIDTH+atct_pkg::CODE_WIDTH+atct_pkg::MASK_WIDTH+7)/8)*8-1:0]
                                                   rsp_tdata,
   // Threshold writes.
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [atct_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [atct_pkg::THRESH_WIDTH-1:0]       csr_wdata
);

   localparam int RSP_DATA_WIDTH =
      ((TIME_WIDTH + atct_pkg::CODE_WIDTH + atct_pkg::MASK_WIDTH + 7) / 8) * 8;
   localparam int RSP_FIELD_WIDTH =
      TIME_WIDTH + atct_pkg::CODE_WIDTH + atct_pkg::MASK_WIDTH;

   // Threshold registers. Writes are taken at any time; the user only writes
   // while no sample is in flight.
   atct_pkg::thresh_type thresh_ff, thresh_in;

   assign csr_ready = 1'b1;

   always_comb begin
      thresh_in = thresh_ff;
      if (csr_valid) begin
         unique case (csr_index)
            atct_pkg::CSR_LOW_NEG:  thresh_in.low_neg  = csr_wdata;
            atct_pkg::CSR_HIGH_NEG: thresh_in.high_neg = csr_wdata;
            atct_pkg::CSR_HIGH_POS: thresh_in.high_pos = csr_wdata;
            default: ;
         endcase
      end
   end

   // Input stage: holds one accepted request until the result register can
   // take its outcome. The whole pipeline moves when the result register is
   // free or being drained.
   logic                           in_valid_ff, in_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] in_sample_ff;
   logic [TIME_WIDTH-1:0]          in_time_ff;
   logic                           in_first_ff;

   logic                           rsp_valid_ff, rsp_valid_in;
   atct_pkg::cross_code_type       rsp_code_ff;
   logic [TIME_WIDTH-1:0]          rsp_time_ff;
   logic [atct_pkg::MASK_WIDTH-1:0] rsp_mask_ff;

   logic out_free;
   logic advance;
   logic req_accept;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_accept = req_tvalid && req_tready;

   assign in_valid_in  = req_accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   // Per-signal state. A first sample starts from cleared flags and a zero
   // previous sample.
   logic signed [SAMPLE_WIDTH-1:0]  prev_ff, prev_in;
   logic [atct_pkg::MASK_WIDTH-1:0] flags_ff, flags_in;
   logic signed [SAMPLE_WIDTH-1:0]  prev_use;
   logic [atct_pkg::MASK_WIDTH-1:0] flags_use;
   logic [atct_pkg::MASK_WIDTH-1:0] flags_next;
   atct_pkg::cross_code_type        code;

   assign prev_use  = in_first_ff ? '0 : prev_ff;
   assign flags_use = in_first_ff ? '0 : flags_ff;

   atct_eval #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_eval (
      .sample      (in_sample_ff),
      .prev_sample (prev_use),
      .flags       (flags_use),
      .thresh      (thresh_ff),
      .code        (code),
      .flags_next  (flags_next)
   );

   assign prev_in  = advance ? in_sample_ff : prev_ff;
   assign flags_in = advance ? flags_next : flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff.low_neg  <= atct_pkg::LOW_NEG_RESET;
         thresh_ff.high_neg <= atct_pkg::HIGH_NEG_RESET;
         thresh_ff.high_pos <= atct_pkg::HIGH_POS_RESET;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prev_ff      <= '0;
         flags_ff     <= '0;
      end else begin
         thresh_ff    <= thresh_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_ff      <= prev_in;
         flags_ff     <= flags_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_sample_ff <= req_tdata[SAMPLE_WIDTH-1:0];
         in_time_ff   <= req_tdata[SAMPLE_WIDTH+TIME_WIDTH-1:SAMPLE_WIDTH];
         in_first_ff  <= req_tuser;
      end
      if (advance) begin
         rsp_code_ff <= code;
         rsp_time_ff <= (code == atct_pkg::CROSS_NONE) ? '0 : in_time_ff;
         rsp_mask_ff <= flags_next;
      end
   end

   logic [RSP_FIELD_WIDTH-1:0] rsp_fields;

   assign rsp_fields = {rsp_mask_ff, rsp_time_ff, rsp_code_ff};
   assign rsp_tdata  = RSP_DATA_WIDTH'(rsp_fields);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

>>> sv/atct_eval.sv
// Compares one sample against the previous one and picks the latch that
// fires, in the fixed order R0, R1, R3, R2, R4.
module atct_eval #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic signed [SAMPLE_WIDTH-1:0]    sample,
   input  logic signed [SAMPLE_WIDTH-1:0]    prev_sample,
   input  logic [atct_pkg::MASK_WIDTH-1:0]   flags,
   input  atct_pkg::thresh_type              thresh,
   output atct_pkg::cross_code_type          code,
   output logic [atct_pkg::MASK_WIDTH-1:0]   flags_next
);

   localparam int CMP_WIDTH = (SAMPLE_WIDTH > atct_pkg::THRESH_WIDTH) ?
                              SAMPLE_WIDTH : atct_pkg::THRESH_WIDTH;

   logic signed [CMP_WIDTH-1:0] y;
   logic signed [CMP_WIDTH-1:0] p;
   logic signed [CMP_WIDTH-1:0] lo;
   logic signed [CMP_WIDTH-1:0] hn;
   logic signed [CMP_WIDTH-1:0] hp;
   logic is_neg;
   logic is_pos;
   logic down_low;
   logic down_high;
   logic up_high;

   assign y  = CMP_WIDTH'(sample);
   assign p  = CMP_WIDTH'(prev_sample);
   assign lo = CMP_WIDTH'(thresh.low_neg);
   assign hn = CMP_WIDTH'(thresh.high_neg);
   assign hp = CMP_WIDTH'(thresh.high_pos);

   assign is_neg = sample[SAMPLE_WIDTH-1];
   assign is_pos = !sample[SAMPLE_WIDTH-1] && (|sample);

   assign down_low  = is_neg && (p >= lo) && (y <= lo);
   assign down_high = is_neg && (p >= hn) && (y <= hn);
   assign up_high   = is_pos && (p <= hp) && (y >= hp);

   always_comb begin
      flags_next = flags;
      priority if (down_low && !flags[atct_pkg::FLAG_R0]) begin
         code = atct_pkg::CROSS_R0;
         flags_next[atct_pkg::FLAG_R0] = 1'b1;
      end else if (down_high && flags[atct_pkg::FLAG_R0] &&
                   !flags[atct_pkg::FLAG_R1]) begin
         code = atct_pkg::CROSS_R1;
         flags_next[atct_pkg::FLAG_R1] = 1'b1;
      end else if (down_high && flags[atct_pkg::FLAG_R0] &&
                   !flags[atct_pkg::FLAG_R3]) begin
         code = atct_pkg::CROSS_R3;
         flags_next[atct_pkg::FLAG_R3] = 1'b1;
      end else if (up_high && flags[atct_pkg::FLAG_R0] &&
                   !flags[atct_pkg::FLAG_R2]) begin
         code = atct_pkg::CROSS_R2;
         flags_next[atct_pkg::FLAG_R2] = 1'b1;
      end else if (up_high && flags[atct_pkg::FLAG_R0] &&
                   !flags[atct_pkg::FLAG_R4]) begin
         code = atct_pkg::CROSS_R4;
         flags_next[atct_pkg::FLAG_R4] = 1'b1;
      end else begin
         code = atct_pkg::CROSS_NONE;
      end
   end

endmodule

>>> sv/atct_checker.sv
// Port-level checks for the crossing timer.
module atct_checker #(
   parameter int TIME_WIDTH = 16
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [((TIME_WIDTH+atct_pkg::CODE_WIDTH+atct_pkg::MASK_WIDTH+7)/8)*8-1:0]
                                   rsp_tdata
);

   localparam int TIME_LSB = atct_pkg::CODE_WIDTH;
   localparam int MASK_LSB = atct_pkg::CODE_WIDTH + TIME_WIDTH;

   logic [atct_pkg::CODE_WIDTH-1:0] code;
   logic [TIME_WIDTH-1:0]           ctime;
   logic [atct_pkg::MASK_WIDTH-1:0] mask;

   assign code  = rsp_tdata[atct_pkg::CODE_WIDTH-1:0];
   assign ctime = rsp_tdata[MASK_LSB-1:TIME_LSB];
   assign mask  = rsp_tdata[MASK_LSB+atct_pkg::MASK_WIDTH-1:MASK_LSB];

   // Nothing comes out right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A stalled result holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // No crossing means a zero time.
   a_none_time: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && code == atct_pkg::CROSS_NONE |-> ctime == '0)
      else $error("time reported without a crossing");

   // Every latch that fires needs R0 set; R3 and R4 also need the flag of R1 or R2 and their own.
   a_r0_first: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && code != atct_pkg::CROSS_NONE |-> mask[atct_pkg::FLAG_R0])
      else $error("crossing reported without R0 set");

   a_own_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (code == atct_pkg::CROSS_R3 || code == atct_pkg::CROSS_R4) |->
         (code == atct_pkg::CROSS_R3 && mask[atct_pkg::FLAG_R1] && mask[atct_pkg::FLAG_R3]) ||
         (code == atct_pkg::CROSS_R4 && mask[atct_pkg::FLAG_R2] && mask[atct_pkg::FLAG_R4]))
      else $error("second crossing without its first");

endmodule

bind anode_threshold_crossing_timer_top atct_checker #(
   .TIME_WIDTH(TIME_WIDTH)
) u_atct_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
